// ===== hw/rtl/wbps_pkg.sv =====
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

  localparam int unsigned PatternMaxDef = 16;
  localparam int unsigned OffsetBitsDef = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PatW     = 64;
  localparam int unsigned CareW    = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CountW   = 16;
  localparam int unsigned OutOffW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3,
    REG_OCC    = 3'd4
  } wbps_reg_e;

  typedef struct packed {
    logic [PatW-1:0]   pat_lo;
    logic [PatW-1:0]   pat_hi;
    logic [CareW-1:0]  care;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] occ;
  } wbps_cfg_t;

endpackage

// ===== hw/rtl/wbps_match.sv =====
// masked compare of the byte window against the configured pattern
module wbps_match #(
  parameter int unsigned PatternMax = wbps_pkg::PatternMaxDef
) (
  input  wbps_pkg::wbps_cfg_t                 cfg_i,
  input  logic [PatternMax*8-1:0]             win_i,
  input  logic [$clog2(PatternMax+1)-1:0]     fill_i,
  output logic [wbps_pkg::LenW-1:0]           len_o,
  output logic                                hit_o
);
  import wbps_pkg::*;

  logic [2*PatW-1:0] pat_all;
  logic [LenW-1:0]   used_len;

  assign pat_all  = {cfg_i.pat_hi, cfg_i.pat_lo};
  assign used_len = (cfg_i.len > LenW'(PatternMax)) ? LenW'(PatternMax) : cfg_i.len;
  assign len_o    = used_len;

  always_comb begin
    logic [7:0] sel;
    sel   = 8'h00;
    hit_o = (used_len != '0) && (LenW'(fill_i) >= used_len);
    for (int j = 0; j < int'(PatternMax); j++) begin
      // window entry len-1-j lines up with pattern byte j
      sel = 8'h00;
      for (int k = 0; k < int'(PatternMax); k++) begin
        if (k + j + 1 == int'(used_len)) begin
          sel = win_i[8*k +: 8];
        end
      end
      if ((j < int'(used_len)) && cfg_i.care[j] && (sel != pat_all[8*j +: 8])) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scanner.sv =====
// top level of the wildcard byte pattern scanner
// Usage: an image streams in one byte per item on the input channel
// (image_byte_i, last_byte_i marks the final byte). Each byte enters a
// sliding window that is compared with a pattern of up to PatternMax bytes,
// where clear care bits are wildcards. Matches are counted in image order;
// the start offset of the match numbered occurrence_index is emitted as soon
// as it is seen (found_o = 1). If the image ends without it, one item with
// found_o = 0 and offset 0 is emitted on the last byte. At most one result
// item per image; after the last byte the scan state clears.
// Throughput: one byte per cycle while the result register can advance, set
// by the combinational window compare between the input and result registers.
// A byte is registered in the input register, its result in the result register.
// Stalls: while the result register is full and out_ready_i is low, one
// more byte may be held in the input register, then in_ready_o drops.
// Reset: registers return to their defaults (pattern_length 1, rest 0) and
// the scan state clears. Configuration writes take effect at once; the user
// must make them only while the block is idle, which the block does not enforce.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned PatternMax = wbps_pkg::PatternMaxDef,
  parameter int unsigned OffsetBits = wbps_pkg::OffsetBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     image_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [wbps_pkg::OutOffW-1:0]   match_offset_o
);
  import wbps_pkg::*;

  localparam int unsigned FillW = $clog2(PatternMax + 1);
  localparam int unsigned ExtW  = (OffsetBits > OutOffW) ? OffsetBits : OutOffW;

  wbps_cfg_t cfg_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  logic [PatternMax*8-1:0] win_q, win_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic [OffsetBits-1:0]   pos_q;
  logic [CountW-1:0]       seen_q;
  logic                    reported_q;

  logic               out_valid_q;
  logic               found_q;
  logic [OutOffW-1:0] off_q, off_d;

  logic              adv;
  logic              hit;
  logic              take;
  logic              count;
  logic              emit;
  logic [LenW-1:0]   used_len;
  logic [OffsetBits-1:0] start;
  logic [ExtW-1:0]   start_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo <= '0;
      cfg_q.pat_hi <= '0;
      cfg_q.care   <= '0;
      cfg_q.len    <= LenW'(1);
      cfg_q.occ    <= '0;
    end else if (cfg_we_i) begin
      case (wbps_reg_e'(cfg_idx_i))
        REG_PAT_LO: cfg_q.pat_lo <= cfg_data_i[PatW-1:0];
        REG_PAT_HI: cfg_q.pat_hi <= cfg_data_i[PatW-1:0];
        REG_CARE:   cfg_q.care   <= cfg_data_i[CareW-1:0];
        REG_LEN:    cfg_q.len    <= cfg_data_i[LenW-1:0];
        REG_OCC:    cfg_q.occ    <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= image_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // window with the new byte shifted in
  always_comb begin
    win_d[7:0] = s1_byte_q;
    for (int k = 1; k < int'(PatternMax); k++) begin
      win_d[8*k +: 8] = win_q[8*(k-1) +: 8];
    end
  end

  assign fill_d = (fill_q == FillW'(PatternMax)) ? fill_q : fill_q + FillW'(1);

  wbps_match #(
    .PatternMax(PatternMax)
  ) u_match (
    .cfg_i (cfg_q),
    .win_i (win_d),
    .fill_i(fill_d),
    .len_o (used_len),
    .hit_o (hit)
  );

  assign take  = hit && !reported_q && (seen_q == cfg_q.occ);
  assign count = hit && !reported_q && (seen_q != cfg_q.occ) && (seen_q != '1);
  assign emit  = take || (s1_last_q && !reported_q);

  assign start     = pos_q - (OffsetBits'(used_len) - OffsetBits'(1));
  assign start_ext = ExtW'(start);
  assign off_d     = take ? start_ext[OutOffW-1:0] : '0;

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      fill_q     <= '0;
      pos_q      <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (adv) begin
      if (s1_last_q) begin
        win_q      <= '0;
        fill_q     <= '0;
        pos_q      <= '0;
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        win_q      <= win_d;
        fill_q     <= fill_d;
        pos_q      <= pos_q + OffsetBits'(1);
        seen_q     <= count ? seen_q + CountW'(1) : seen_q;
        reported_q <= reported_q || take;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      found_q <= take;
      off_q   <= off_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = off_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(PatternMax))
    else $error("window fill beyond pattern max");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_last_q |=> (pos_q == '0) && !reported_q && (fill_q == '0))
    else $error("scan state not cleared after last byte");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> off_q == '0)
    else $error("not-found result carries an offset");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");
`endif

endmodule
